### rtl/b32c_pkg.sv
`default_nettype none
package b32c_pkg;

   // Field widths of the request and result items.
   localparam int DATA_IN_WIDTH  = 16;
   localparam int DATA_OUT_WIDTH = 8;

   // Bit accumulator sizing and group sizes per direction.
   localparam int ACC_WIDTH  = 12;
   localparam int HELD_WIDTH = 4;
   localparam int CNT_WIDTH  = 2;
   localparam int ENC_BITS   = 5;
   localparam int DEC_BITS   = 8;

   // Register map.
   localparam int          PADDR_WIDTH = 3;
   localparam logic        REG_DIRECTION = 1'b0;
   localparam logic        DIR_ENCODE = 1'b0;
   localparam logic        DIR_DECODE = 1'b1;

   // Character codes used by the decode mapping.
   localparam logic [15:0] CHAR_AT      = 16'h0040;
   localparam logic [15:0] CHAR_A       = 16'h0041;
   localparam logic [15:0] CHAR_C       = 16'h0043;
   localparam logic [15:0] CHAR_H       = 16'h0048;
   localparam logic [15:0] CHAR_N       = 16'h004E;
   localparam logic [15:0] CHAR_Z       = 16'h005A;
   localparam logic [15:0] CHAR_DASH    = 16'h002D;
   localparam logic [15:0] CASE_BIT     = 16'h0020;
   localparam logic [5:0]  OFFSET_ZERO  = 6'd48;
   localparam logic [5:0]  OFFSET_ALPHA = 6'd7;
   localparam logic [4:0]  VALUE_MAX    = 5'h1F;

   // The 32-letter alphabet, indexed by a 5-bit group.
   localparam logic [7:0] LETTER_TABLE [32] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h43, 8'h45, 8'h46, 8'h47, 8'h48,
      8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52,
      8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
   };

   typedef struct packed {
      logic [DATA_IN_WIDTH-1:0] data_in;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic [DATA_OUT_WIDTH-1:0] data_out;
      logic                      last_out;
   } rsp_type;

   // One classified request: the filled accumulator and how many results it yields.
   typedef struct packed {
      logic [ACC_WIDTH-1:0] acc;
      logic [CNT_WIDTH-1:0] count;
      logic                 dir;
      logic                 last;
   } job_type;

   // Maps a character code to its 5-bit value, folding lower case to upper case.
   function automatic logic [4:0] char_value(input logic [15:0] code);
      logic [15:0] c;
      logic [5:0]  off;
      c   = code;
      off = OFFSET_ZERO;
      if (c > CHAR_AT) c = c & ~CASE_BIT;
      if (c > CHAR_AT) off = off + OFFSET_ALPHA;
      if (c > CHAR_A) off = off + 6'd1;
      if (c > CHAR_C) off = off + 6'd1;
      if (c > CHAR_H) off = off + 6'd1;
      if (c > CHAR_N) off = off + 6'd1;
      if (c == CHAR_DASH || c > CHAR_Z) begin
         return VALUE_MAX;
      end
      return c[4:0] - off[4:0];
   endfunction

endpackage
`default_nettype wire

### rtl/b32c_front.sv
`default_nettype none
module b32c_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              dir,
   input  wire logic              clear,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire b32c_pkg::req_type req_data,
   output logic                   job_valid,
   input  wire logic              job_ready,
   output b32c_pkg::job_type      job_data
);

   logic [b32c_pkg::ACC_WIDTH-1:0]  acc_ff, acc_in;
   logic [b32c_pkg::HELD_WIDTH-1:0] held_ff, held_in;

   logic [b32c_pkg::ACC_WIDTH-1:0]  acc_sum;
   logic [b32c_pkg::HELD_WIDTH-1:0] held_sum;
   logic [b32c_pkg::HELD_WIDTH-1:0] held_rest;
   logic [b32c_pkg::ACC_WIDTH-1:0]  acc_rest;
   logic [b32c_pkg::CNT_WIDTH-1:0]  full_groups;
   logic [b32c_pkg::CNT_WIDTH-1:0]  count;
   logic [4:0]                      value;
   logic                            accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = job_ready;
   assign value     = b32c_pkg::char_value(req_data.data_in);

   // Insert the new bits above those held and work out how many full groups leave.
   always_comb begin
      acc_sum     = acc_ff;
      held_sum    = held_ff;
      full_groups = '0;
      held_rest   = held_ff;
      acc_rest    = acc_ff;
      if (dir == b32c_pkg::DIR_ENCODE) begin
         acc_sum  = acc_ff | (b32c_pkg::ACC_WIDTH'(req_data.data_in[7:0]) << held_ff);
         held_sum = held_ff + b32c_pkg::HELD_WIDTH'(b32c_pkg::DEC_BITS);
         if (held_sum >= b32c_pkg::HELD_WIDTH'(2 * b32c_pkg::ENC_BITS)) begin
            full_groups = 2'd2;
            held_rest   = held_sum - b32c_pkg::HELD_WIDTH'(2 * b32c_pkg::ENC_BITS);
            acc_rest    = acc_sum >> (2 * b32c_pkg::ENC_BITS);
         end else begin
            full_groups = 2'd1;
            held_rest   = held_sum - b32c_pkg::HELD_WIDTH'(b32c_pkg::ENC_BITS);
            acc_rest    = acc_sum >> b32c_pkg::ENC_BITS;
         end
      end else begin
         acc_sum  = acc_ff | (b32c_pkg::ACC_WIDTH'(value) << held_ff);
         held_sum = held_ff + b32c_pkg::HELD_WIDTH'(b32c_pkg::ENC_BITS);
         if (held_sum >= b32c_pkg::HELD_WIDTH'(b32c_pkg::DEC_BITS)) begin
            full_groups = 2'd1;
            held_rest   = held_sum - b32c_pkg::HELD_WIDTH'(b32c_pkg::DEC_BITS);
            acc_rest    = acc_sum >> b32c_pkg::DEC_BITS;
         end else begin
            full_groups = 2'd0;
            held_rest   = held_sum;
            acc_rest    = acc_sum;
         end
      end
      // A last request flushes any partial group as one more result.
      count = full_groups;
      if (req_data.last_in && held_rest != '0) count = full_groups + 2'd1;
   end

   // Only requests that yield results are queued for the back end.
   assign job_valid      = accept && (count != '0);
   assign job_data.acc   = acc_sum;
   assign job_data.count = count;
   assign job_data.dir   = dir;
   assign job_data.last  = req_data.last_in;

   // Accumulator state carried to the next request.
   always_comb begin
      acc_in  = acc_ff;
      held_in = held_ff;
      if (clear) begin
         acc_in  = '0;
         held_in = '0;
      end else if (accept) begin
         if (req_data.last_in) begin
            acc_in  = '0;
            held_in = '0;
         end else begin
            acc_in  = acc_rest;
            held_in = held_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

### rtl/b32c_queue.sv
`default_nettype none
module b32c_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire b32c_pkg::job_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output b32c_pkg::job_type      pop_data
);

   b32c_pkg::job_type entries_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push, pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) fill_in = fill_ff + 2'd1;
      if (pop && !push) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

### rtl/b32c_back.sv
`default_nettype none
module b32c_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire b32c_pkg::job_type job_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output b32c_pkg::rsp_type      rsp_data
);

   b32c_pkg::job_type work_ff, work_in;
   logic              busy_ff, busy_in;
   logic              out_valid_ff, out_valid_in;
   b32c_pkg::rsp_type out_data_ff, out_data_in;
   logic              emit;
   logic              work_load;

   // A result is produced whenever a request is in work and the output register is free or being emptied.
   assign emit      = busy_ff && (!out_valid_ff || rsp_ready);
   assign work_load = !busy_ff || (emit && work_ff.count == 2'd1);
   assign job_ready = work_load;

   // Working register: shift out one group per result, then take the next request.
   always_comb begin
      busy_in = busy_ff;
      work_in = work_ff;
      if (emit) begin
         if (work_ff.dir == b32c_pkg::DIR_ENCODE) begin
            work_in.acc = work_ff.acc >> b32c_pkg::ENC_BITS;
         end else begin
            work_in.acc = work_ff.acc >> b32c_pkg::DEC_BITS;
         end
         work_in.count = work_ff.count - 2'd1;
         if (work_ff.count == 2'd1) busy_in = 1'b0;
      end
      if (work_load && job_valid) begin
         work_in = job_data;
         busy_in = 1'b1;
      end
   end

   // Output register contents.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         if (work_ff.dir == b32c_pkg::DIR_ENCODE) begin
            out_data_in.data_out = b32c_pkg::LETTER_TABLE[work_ff.acc[4:0]];
         end else begin
            out_data_in.data_out = work_ff.acc[7:0];
         end
         out_data_in.last_out = work_ff.last && (work_ff.count == 2'd1);
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      out_data_ff <= out_data_in;
   end

endmodule
`default_nettype wire

### rtl/base32_text_binary_codec_unit.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_ready  req_data  (data_in, last_in)
// result    out        rsp_valid/rsp_ready  rsp_data  (data_out, last_out)
// control   in/out     APB psel/penable     paddr, pwdata, prdata (direction at 0)
//
// The front end takes one request per cycle while the two-entry job queue has room.
// The back end sends one result per cycle from its output register while rsp_ready
// is high; encoding gives one or two results per byte, one more on a last byte that flushes.
// Decoding gives at most one result per character, one more on a last character that both
// completes a byte and flushes; a character may give no result.
// Reset clears the accumulator, the queue and the output register at once.
// Either side may stall; the queue and output register hold their contents.
module base32_text_binary_codec_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire b32c_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output b32c_pkg::rsp_type                    rsp_data,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [b32c_pkg::PADDR_WIDTH-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   logic              dir_ff, dir_in;
   logic              dir_write;
   logic              front_valid, front_ready;
   b32c_pkg::job_type front_job;
   logic              back_valid, back_ready;
   b32c_pkg::job_type back_job;

   // Register port: the direction register lives at word zero.
   assign pready    = 1'b1;
   assign dir_write = psel && penable && pwrite && pready &&
                      (paddr[2] == b32c_pkg::REG_DIRECTION);
   assign dir_in    = dir_write ? pwdata[0] : dir_ff;
   assign prdata    = (paddr[2] == b32c_pkg::REG_DIRECTION) ? {31'b0, dir_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= b32c_pkg::DIR_ENCODE;
      end else begin
         dir_ff <= dir_in;
      end
   end

   b32c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .dir       (dir_ff),
      .clear     (dir_write),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job_data  (front_job)
   );

   b32c_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   b32c_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_data  (back_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### verif/base32_text_binary_codec_unit_tb.sv
`timescale 1ns / 100ps
module base32_text_binary_codec_unit_tb;
   import b32c_pkg::*;

   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS   = 53;

   localparam logic [PADDR_WIDTH-1:0] ADDR_DIRECTION = 3'd0;
   localparam logic [PADDR_WIDTH-1:0] ADDR_UNMAPPED  = 3'd4;

   localparam logic [8*32-1:0] ALPHABET = "0123456789ACEFGHJKLMNPQRSTUVWXYZ";

   localparam logic [15:0] CODE_AT   = 16'h0040;
   localparam logic [15:0] CODE_A    = 16'h0041;
   localparam logic [15:0] CODE_C    = 16'h0043;
   localparam logic [15:0] CODE_H    = 16'h0048;
   localparam logic [15:0] CODE_N    = 16'h004E;
   localparam logic [15:0] CODE_Z    = 16'h005A;
   localparam logic [15:0] CODE_DASH = 16'h002D;
   localparam logic [15:0] CASE_FOLD = 16'h0020;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [PADDR_WIDTH-1:0] paddr;
   logic [31:0]            pwdata;
   logic [31:0]            prdata;
   logic                   pready;

   // Mirror of the codec state and its direction setting.
   logic       model_dir;
   logic [11:0] model_acc;
   logic [3:0] model_held;

   req_type queued_requests[$];
   rsp_type awaited_symbols[$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int quiet_cycles;

   base32_text_binary_codec_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] letter_for(input logic [4:0] group);
      return ALPHABET[8*(31-group) +: 8];
   endfunction

   // Folds lower case to upper case and maps a character to its 5-bit value.
   function automatic logic [4:0] char_value_of(input logic [15:0] code);
      logic [15:0] c;
      logic [15:0] off;
      logic [15:0] diff;
      c   = code;
      off = 16'd48;
      if (c > CODE_AT) c = c & ~CASE_FOLD;
      if (c > CODE_AT) off = off + 16'd7;
      if (c > CODE_A) off = off + 16'd1;
      if (c > CODE_C) off = off + 16'd1;
      if (c > CODE_H) off = off + 16'd1;
      if (c > CODE_N) off = off + 16'd1;
      if (c == CODE_DASH || c > CODE_Z) return 5'h1F;
      diff = c - off;
      return diff[4:0];
   endfunction

   // Works out the results of one accepted request and queues them.
   task automatic predict_codec_step(input req_type r);
      rsp_type outs [3];
      int      n;
      n = 0;
      if (model_dir == DIR_ENCODE) begin
         model_acc  = model_acc | (12'(r.data_in[7:0]) << model_held);
         model_held = model_held + 4'd8;
         while (model_held >= 4'd5) begin
            outs[n].data_out = letter_for(model_acc[4:0]);
            outs[n].last_out = 1'b0;
            n++;
            model_acc  = model_acc >> 5;
            model_held = model_held - 4'd5;
         end
         if (r.last_in && model_held != 4'd0) begin
            outs[n].data_out = letter_for(model_acc[4:0]);
            outs[n].last_out = 1'b0;
            n++;
         end
      end else begin
         model_acc  = model_acc | (12'(char_value_of(r.data_in)) << model_held);
         model_held = model_held + 4'd5;
         while (model_held >= 4'd8) begin
            outs[n].data_out = model_acc[7:0];
            outs[n].last_out = 1'b0;
            n++;
            model_acc  = model_acc >> 8;
            model_held = model_held - 4'd8;
         end
         if (r.last_in && model_held != 4'd0) begin
            outs[n].data_out = model_acc[7:0];
            outs[n].last_out = 1'b0;
            n++;
         end
      end
      // The final item of a message clears the state and tags its last result.
      if (r.last_in) begin
         model_acc  = '0;
         model_held = '0;
         if (n > 0) outs[n-1].last_out = 1'b1;
      end
      for (int i = 0; i < n; i++) awaited_symbols.push_back(outs[i]);
   endtask

   // Request driver: offers the next queued request once the previous one has gone.
   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_codec_step(req_data);
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= queued_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_symbols.size() == 0) begin
               $error("unexpected result: data_out %h, last_out %b",
                      rsp_data.data_out, rsp_data.last_out);
               error_count++;
            end else begin
               want = awaited_symbols.pop_front();
               if (rsp_data.data_out !== want.data_out) begin
                  $error("data_out: expected %h, actual %h", want.data_out, rsp_data.data_out);
                  error_count++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $error("last_out: expected %b, actual %b", want.last_out, rsp_data.last_out);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Register write: setup cycle, then access cycle; the mirror follows on completion.
   task automatic write_register(input logic [PADDR_WIDTH-1:0] addr, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_DIRECTION) begin
         model_dir  = value[0];
         model_acc  = '0;
         model_held = '0;
      end
   endtask

   task automatic queue_request(input logic [15:0] code, input logic last);
      req_type r;
      r.data_in = code;
      r.last_in = last;
      queued_requests.push_back(r);
   endtask

   // Holds back new requests until every expected result has come and the block is quiet.
   // The check is made between clock edges so that the driver's updates have settled.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || awaited_symbols.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed messages with random content, with some early or missing ends.
   task automatic queue_random_messages(input logic dir, input int item_budget);
      int          left;
      int          len;
      int          pick;
      logic [4:0]  group;
      logic [15:0] code;
      logic        last;
      left = item_budget;
      while (left > 0) begin
         len = $urandom_range(12, 1);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) begin
            if (dir == DIR_ENCODE) begin
               code = 16'($urandom_range(16'hFFFF));
            end else begin
               pick = $urandom_range(9);
               if (pick < 7) begin
                  group = 5'($urandom_range(31));
                  code  = {8'h00, letter_for(group)};
                  if (code > CODE_AT && $urandom_range(1) == 1) code = code | CASE_FOLD;
               end else if (pick == 7) begin
                  code = CODE_DASH;
               end else begin
                  code = 16'($urandom_range(16'hFFFF));
               end
            end
            if (i == len - 1) last = ($urandom_range(7) != 0);
            else last = ($urandom_range(19) == 0);
            queue_request(code, last);
         end
         left -= len;
      end
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      model_dir     = DIR_ENCODE;
      model_acc     = '0;
      model_held    = '0;
      error_count   = 0;
      quiet_cycles  = 0;
      send_idle_pct = 31;
      recv_idle_pct = 49;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Encoding straight after reset: byte extremes, ignored upper bits, flushes.
      queue_request(16'h0000, 1'b1);
      queue_request(16'hFFFF, 1'b1);
      queue_request(16'h5AA5, 1'b0);
      queue_request(16'h00FF, 1'b0);
      queue_request(16'h8001, 1'b0);
      queue_request(16'h7F3C, 1'b1);
      wait_until_drained();

      // Decoding: every step of the mapping, case folding, dash, out-of-alphabet codes.
      write_register(ADDR_DIRECTION, {31'b0, DIR_DECODE});
      queue_request("0", 1'b0);
      queue_request("9", 1'b0);
      queue_request("@", 1'b0);
      queue_request("A", 1'b0);
      queue_request("B", 1'b0);
      queue_request("C", 1'b0);
      queue_request("D", 1'b0);
      queue_request("H", 1'b0);
      queue_request("I", 1'b0);
      queue_request("N", 1'b0);
      queue_request("O", 1'b0);
      queue_request("Z", 1'b0);
      queue_request("a", 1'b0);
      queue_request("z", 1'b0);
      queue_request("-", 1'b0);
      queue_request(" ", 1'b0);
      queue_request(16'h007F, 1'b0);
      queue_request(16'hFFFF, 1'b0);
      queue_request(16'h0000, 1'b1);
      wait_until_drained();

      // A direction write in the middle of a message drops the bits held so far.
      queue_request("A", 1'b0);
      queue_request("B", 1'b0);
      queue_request("C", 1'b0);
      wait_until_drained();
      write_register(ADDR_DIRECTION, 32'hFFFF_FFFF);
      queue_request("Z", 1'b1);
      wait_until_drained();

      // A write to an unmapped address leaves both the setting and the message alone.
      write_register(ADDR_DIRECTION, 32'hFFFF_FFFE);
      queue_request(16'h00AB, 1'b0);
      wait_until_drained();
      write_register(ADDR_UNMAPPED, 32'h0000_0001);
      queue_request(16'h0012, 1'b1);
      wait_until_drained();

      // Random messages in both directions under each idling pattern.
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 49;
            end
            1: begin
               send_idle_pct = 49;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_register(ADDR_DIRECTION, {31'b0, DIR_ENCODE});
         queue_random_messages(DIR_ENCODE, PHASE_ITEMS);
         wait_until_drained();
         write_register(ADDR_DIRECTION, {31'b0, DIR_DECODE});
         queue_random_messages(DIR_DECODE, PHASE_ITEMS);
         wait_until_drained();
      end

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
